@@ design/ascending_integer_sorter_macros.svh @@
// Assertion macros for the ascending integer sorter.
// Included by modules that carry concurrent checks.
`ifndef ASCENDING_INTEGER_SORTER_MACROS_SVH
`define ASCENDING_INTEGER_SORTER_MACROS_SVH
`ifndef SYNTHESIS
`define AIS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AIS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AIS_ASSERT(label, clk, rst_n, prop, msg)
`define AIS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ design/ais_pkg.sv @@
// Shared constants and types for the ascending integer sorter.
// No dependencies.
package ais_pkg;
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    typedef logic signed [31:0] data_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
endpackage

@@ design/ascending_integer_sorter.sv @@
// Batch sorter: a load phase fills a RAM one beat per cycle, then an insertion sort runs
// over the RAM using one read port and one write port, then the batch is read out in order.
// Depends on ais_pkg, ais_ram and ascending_integer_sorter_macros.svh.
//
// Loading takes one beat per cycle. After the closing beat, insertion sort reads each element
// and its left neighbour, shifting each larger element up one slot until its place (or slot
// 0) is found; readout alternates a RAM read with holding the beat until the sink is ready.
// A new batch is taken only after the last beat leaves.
`include "ascending_integer_sorter_macros.svh"
module ascending_integer_sorter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ais_pkg::data_t      value,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output ais_pkg::data_t      sorted_value,
    output logic                end_of_batch,
    output logic                overflow
);
    import ais_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_OUTER = 3'd1; // read element i
    localparam logic [2:0] S_CUR   = 3'd2; // capture cur, read j-1
    localparam logic [2:0] S_CMP   = 3'd3; // compare store[j-1] with cur
    localparam logic [2:0] S_RD    = 3'd4; // read data captured into the output register
    localparam logic [2:0] S_OUT   = 3'd5; // output register holds a beat
    localparam logic [2:0] S_PUT   = 3'd6; // place cur at slot 0

    logic [2:0] state_reg, state_next;
    cnt_t  count_reg, count_next;
    logic  drop_reg, drop_next;
    cnt_t  i_reg, i_next;
    cnt_t  j_reg, j_next;
    data_t cur_reg, cur_next;
    data_t out_reg, out_next;
    logic  eob_reg, eob_next;

    logic  we;
    addr_t waddr, raddr;
    data_t wdata, rdata;
    logic  eob_accept;

    ais_ram #(.DEPTH(MAX_ITEMS), .WIDTH(32)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign in_ready     = (state_reg == S_LOAD);
    assign out_valid    = (state_reg == S_OUT);
    assign sorted_value = out_reg;
    assign end_of_batch = eob_reg;
    assign overflow     = drop_reg;
    assign eob_accept   = out_valid && out_ready && end_of_batch;

    // Control and RAM access sequencing
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        out_next   = out_reg;
        eob_next   = eob_reg;
        we    = 1'b0;
        waddr = count_reg[ADDR_W-1:0];
        wdata = value;
        raddr = i_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < cnt_t'(MAX_ITEMS))
                    begin
                        we = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last)
                    begin
                        i_next = cnt_t'(1);
                        state_next = S_OUTER;
                    end
                end
            end
            S_OUTER:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next = '0;
                    raddr = '0;
                    state_next = S_RD;
                end
                else
                begin
                    raddr = i_reg[ADDR_W-1:0];
                    j_next = i_reg;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cur_next = rdata;
                raddr = ADDR_W'(j_reg - cnt_t'(1));
                state_next = S_CMP;
            end
            S_CMP:
            begin
                we = 1'b1;
                waddr = j_reg[ADDR_W-1:0];
                if (rdata > cur_reg)
                begin
                    // shift the larger element up one slot
                    wdata = rdata;
                    j_next = j_reg - cnt_t'(1);
                    if (j_reg == cnt_t'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        raddr = ADDR_W'(j_reg - cnt_t'(2));
                    end
                end
                else
                begin
                    wdata = cur_reg;
                    i_next = i_reg + cnt_t'(1);
                    state_next = S_OUTER;
                end
            end
            S_PUT:
            begin
                we = 1'b1;
                waddr = '0;
                wdata = cur_reg;
                i_next = i_reg + cnt_t'(1);
                state_next = S_OUTER;
            end
            S_RD:
            begin
                out_next = rdata;
                eob_next = (i_reg + cnt_t'(1) == count_reg);
                i_next = i_reg + cnt_t'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                raddr = i_reg[ADDR_W-1:0];
                if (out_ready)
                begin
                    if (eob_reg)
                    begin
                        count_next = '0;
                        drop_next = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            eob_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            eob_reg   <= eob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    `AIS_ASSERT(a_cnt_range, clk, rst_n, count_reg <= cnt_t'(MAX_ITEMS), "count exceeds capacity")
    `AIS_ASSERT(a_no_both, clk, rst_n, !(in_ready && out_valid), "load and output overlap")
    `AIS_ASSERT(a_eob_clear, clk, rst_n, eob_accept |=> (count_reg == '0 && !overflow), "not cleared")
    `AIS_ASSERT(a_drop_full, clk, rst_n, $rose(drop_reg) |-> count_reg == cnt_t'(MAX_ITEMS), "drop before full")
endmodule

@@ design/ais_ram.sv @@
// Single-port-write, single-read RAM with registered read data.
// No package dependencies.
module ais_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
